// ----- rtl/lspe_pkg.sv -----
// Shared types, codes and color constants of the LED strip pattern engine.
package lspe_pkg;

	localparam int PIX_W   = 24;
	localparam int CIDX_W  = 3;
	localparam int SRC_W   = 2;
	localparam int PCT_W   = 7;
	localparam int PER_W   = 8;
	localparam int DATA_W  = 8;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_PATTERN  = 3'd0;
	localparam logic [2:0] REG_COLOR    = 3'd1;
	localparam logic [2:0] REG_EMERG    = 3'd2;
	localparam logic [2:0] REG_CHARGING = 3'd3;
	localparam logic [2:0] REG_PERCENT  = 3'd4;
	localparam logic [2:0] REG_PERIOD   = 3'd5;

	// Pattern codes.
	localparam logic [2:0] PAT_OFF   = 3'd0;
	localparam logic [2:0] PAT_SOLID = 3'd1;
	localparam logic [2:0] PAT_WIPE  = 3'd2;
	localparam logic [2:0] PAT_FADE  = 3'd3;
	localparam logic [2:0] PAT_BLINK = 3'd4;
	localparam logic [2:0] PAT_IND   = 3'd5;
	localparam logic [2:0] PAT_RIGHT = 3'd6;
	localparam logic [2:0] PAT_LEFT  = 3'd7;

	// Color codes.
	localparam logic [2:0] CSEL_WHITE   = 3'd0;
	localparam logic [2:0] CSEL_RED     = 3'd1;
	localparam logic [2:0] CSEL_GREEN   = 3'd2;
	localparam logic [2:0] CSEL_BLUE    = 3'd3;
	localparam logic [2:0] CSEL_ORANGE  = 3'd4;
	localparam logic [2:0] CSEL_YELLOW  = 3'd5;
	localparam logic [2:0] CSEL_INDIGO  = 3'd6;
	localparam logic [2:0] CSEL_INVALID = 3'd7;

	// Frame source codes.
	localparam logic [1:0] SRC_NORMAL = 2'd0;
	localparam logic [1:0] SRC_GAUGE  = 2'd1;
	localparam logic [1:0] SRC_EMERG  = 2'd2;

	// Packed colors.
	localparam logic [23:0] RGB_WHITE  = 24'hFFFFFF;
	localparam logic [23:0] RGB_RED    = 24'hFF0000;
	localparam logic [23:0] RGB_GREEN  = 24'h00FF00;
	localparam logic [23:0] RGB_BLUE   = 24'h0000FF;
	localparam logic [23:0] RGB_ORANGE = 24'hFF5500;
	localparam logic [23:0] RGB_YELLOW = 24'hFFFF00;
	localparam logic [23:0] RGB_INDIGO = 24'h4B0082;
	localparam logic [23:0] RGB_OFF    = 24'h000000;

	// Blink thresholds and animation constants.
	localparam logic [7:0] GAUGE_THR = 8'd8;
	localparam logic [7:0] IND_THR   = 8'd6;
	localparam logic [7:0] SEG_THR   = 8'd5;
	localparam logic [7:0] FADE_STEP = 8'd5;
	localparam logic [7:0] FADE_MAX  = 8'd255;
	localparam int         GAUGE_DEN = 100;

	// Segment boundaries for a 96-pixel strip, nine bits wide.
	localparam logic [8:0] SEG_MID_LO = 9'd24;
	localparam logic [8:0] SEG_MID_HI = 9'd72;
	localparam logic [8:0] SEG_END    = 9'd96;

	localparam logic [PER_W-1:0] PERIOD_RST = 8'd10;

	typedef struct packed {
		logic [2:0]       pattern_select;
		logic [2:0]       color_select;
		logic             emergency_on;
		logic             charging_on;
		logic [PCT_W-1:0] charge_percent;
		logic [PER_W-1:0] blink_period;
	} cfg_t;

	typedef struct packed {
		logic idle;
		logic done;
	} rstat_t;

	typedef struct packed {
		logic [7:0] cnt;
		logic       lit;
	} blink_t;

	function automatic logic [23:0] color_of(input logic [2:0] sel);
		logic [23:0] c;
		case (sel)
			CSEL_WHITE:  c = RGB_WHITE;
			CSEL_RED:    c = RGB_RED;
			CSEL_GREEN:  c = RGB_GREEN;
			CSEL_BLUE:   c = RGB_BLUE;
			CSEL_ORANGE: c = RGB_ORANGE;
			CSEL_YELLOW: c = RGB_YELLOW;
			CSEL_INDIGO: c = RGB_INDIGO;
			default:     c = RGB_OFF;
		endcase
		return c;
	endfunction

	// One blink step: count up, and on reaching the threshold wrap and toggle.
	function automatic blink_t blink_step(input logic [7:0] cnt, input logic lit,
			input logic [7:0] thr);
		blink_t r;
		r.cnt = cnt + 8'd1;
		r.lit = lit;
		if (r.cnt >= thr) begin
			r.cnt = 8'd0;
			r.lit = ~lit;
		end
		return r;
	endfunction

	// Channel scaled by level/255, truncated; exact for all 8-bit operands.
	function automatic logic [7:0] fade_scale(input logic [7:0] ch, input logic [7:0] lvl);
		logic [15:0] p;
		logic [16:0] s;
		p = ch * lvl;
		s = 17'(p) + 17'(p[15:8]) + 17'd1;
		return s[15:8];
	endfunction

endpackage

// ----- rtl/lspe_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
module lspe_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 96,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- rtl/lspe_render.sv -----
// Frame renderer: animation state, per-frame setup and the pixel write sweep.
module lspe_render import lspe_pkg::*; #(
	parameter int PIXEL_COUNT = 96,
	localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1,
	localparam int CW = PCT_W + AW + 1
) (
	input  logic           clk,
	input  logic           arst_n,
	input  cfg_t           cfg,
	input  logic           restart,
	input  logic           start,
	input  logic           finish,
	output rstat_t         stat,
	output logic           wr_en,
	output logic [AW-1:0]  wr_addr,
	output logic [23:0]    wr_data
);

	typedef enum logic [1:0] {S_IDLE, S_PREP, S_SWEEP, S_DONE} state_t;
	typedef enum logic [1:0] {M_FILL, M_WIPE_CLR, M_GAUGE, M_SEG} mode_t;

	localparam logic [AW-1:0] LAST_IDX = AW'(PIXEL_COUNT - 1);

	state_t state_q;

	// Animation state.
	logic [AW-1:0] pos_q;
	logic [7:0]    cnt_q;
	logic          lit_q;
	logic [7:0]    lvl_q;
	logic          rise_q;

	// Snapshot of the frame's settings.
	logic [2:0]       pat_q;
	logic [2:0]       col_q;
	logic [1:0]       src_q;
	logic [PCT_W-1:0] pct_q;
	logic             wrap_q;

	// Sweep control.
	mode_t         mode_q;
	logic [23:0]   color_q;
	logic          mid_q;
	logic [CW-1:0] gauge_a_q;
	logic [AW-1:0] idx_q;
	logic [AW-1:0] last_q;

	// Next animation state for a tick.
	logic [1:0]    src_n;
	logic [AW-1:0] pos_n;
	logic [7:0]    cnt_n;
	logic          lit_n;
	logic [7:0]    lvl_n;
	logic          rise_n;
	logic          wrap_n;
	logic [AW:0]   pos_inc;
	logic [8:0]    lvl_up;
	blink_t        bstep;
	logic [7:0]    bthr;
	logic          bdo;

	always_comb begin
		src_n   = cfg.emergency_on ? SRC_EMERG : (cfg.charging_on ? SRC_GAUGE : SRC_NORMAL);
		pos_n   = pos_q;
		lvl_n   = lvl_q;
		rise_n  = rise_q;
		wrap_n  = 1'b0;
		bthr    = GAUGE_THR;
		bdo     = 1'b0;
		pos_inc = {1'b0, pos_q} + (AW + 1)'(1);
		lvl_up  = {1'b0, lvl_q} + {1'b0, FADE_STEP};
		if (src_n == SRC_GAUGE) begin
			bdo = 1'b1;
		end else if (src_n == SRC_NORMAL && cfg.color_select != CSEL_INVALID) begin
			case (cfg.pattern_select)
				PAT_WIPE: begin
					if (pos_inc >= (AW + 1)'(PIXEL_COUNT)) begin
						pos_n  = '0;
						wrap_n = 1'b1;
					end else begin
						pos_n = pos_inc[AW-1:0];
					end
				end
				PAT_FADE: begin
					if (rise_q) begin
						if (lvl_up >= {1'b0, FADE_MAX}) begin
							lvl_n  = FADE_MAX;
							rise_n = 1'b0;
						end else begin
							lvl_n = lvl_up[7:0];
						end
					end else if (lvl_q <= FADE_STEP) begin
						lvl_n  = 8'd0;
						rise_n = 1'b1;
					end else begin
						lvl_n = lvl_q - FADE_STEP;
					end
				end
				PAT_BLINK: begin
					bdo  = 1'b1;
					bthr = cfg.blink_period;
				end
				PAT_IND: begin
					bdo  = (cfg.color_select != CSEL_INDIGO);
					bthr = IND_THR;
				end
				PAT_RIGHT, PAT_LEFT: begin
					bdo  = (cfg.color_select != CSEL_INDIGO);
					bthr = SEG_THR;
				end
				default: begin
				end
			endcase
		end
		bstep = blink_step(cnt_q, lit_q, bthr);
		cnt_n = bdo ? bstep.cnt : cnt_q;
		lit_n = bdo ? bstep.lit : lit_q;
	end

	// Frame setup from the updated animation state.
	mode_t         mode_p;
	logic [23:0]   color_p;
	logic [23:0]   base;
	logic [23:0]   faded;
	logic [AW-1:0] start_p;
	logic [AW-1:0] last_p;
	logic          dark;

	always_comb begin
		base    = color_of(col_q);
		faded   = {fade_scale(base[23:16], lvl_q), fade_scale(base[15:8], lvl_q),
			fade_scale(base[7:0], lvl_q)};
		dark    = (col_q == CSEL_INDIGO) || !lit_q;
		mode_p  = M_FILL;
		color_p = RGB_OFF;
		start_p = '0;
		last_p  = LAST_IDX;
		if (src_q == SRC_EMERG) begin
			color_p = RGB_RED;
		end else if (src_q == SRC_GAUGE) begin
			mode_p = M_GAUGE;
		end else if (col_q != CSEL_INVALID) begin
			case (pat_q)
				PAT_SOLID: color_p = base;
				PAT_WIPE: begin
					color_p = base;
					if (wrap_q) begin
						mode_p = M_WIPE_CLR;
					end else begin
						start_p = pos_q;
						last_p  = pos_q;
					end
				end
				PAT_FADE:  color_p = faded;
				PAT_BLINK: color_p = lit_q ? base : RGB_OFF;
				PAT_IND:   color_p = dark ? RGB_OFF : base;
				PAT_RIGHT, PAT_LEFT: begin
					mode_p  = M_SEG;
					color_p = dark ? RGB_OFF : base;
				end
				default:   color_p = RGB_OFF;
			endcase
		end
	end

	// Pixel value at the sweep position.
	logic [CW-1:0] lo;
	logic [CW-1:0] hi;
	logic [8:0]    idx9;
	logic          in_seg;

	always_comb begin
		lo     = CW'(idx_q) * CW'(GAUGE_DEN);
		hi     = lo + CW'(GAUGE_DEN);
		idx9   = 9'(idx_q);
		in_seg = mid_q ? (idx9 >= SEG_MID_LO && idx9 < SEG_MID_HI)
			: (idx9 < SEG_MID_LO || (idx9 >= SEG_MID_HI && idx9 < SEG_END));
		case (mode_q)
			M_FILL:     wr_data = color_q;
			M_WIPE_CLR: wr_data = (idx_q == '0) ? color_q : RGB_OFF;
			M_GAUGE: begin
				if (hi <= gauge_a_q) begin
					wr_data = RGB_GREEN;
				end else if (lit_q && lo <= gauge_a_q) begin
					wr_data = RGB_YELLOW;
				end else begin
					wr_data = RGB_OFF;
				end
			end
			M_SEG:      wr_data = in_seg ? color_q : RGB_OFF;
			default:    wr_data = RGB_OFF;
		endcase
	end

	assign wr_en     = (state_q == S_SWEEP);
	assign wr_addr   = idx_q;
	assign stat.idle = (state_q == S_IDLE);
	assign stat.done = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			pos_q     <= '0;
			cnt_q     <= '0;
			lit_q     <= 1'b1;
			lvl_q     <= '0;
			rise_q    <= 1'b1;
			pat_q     <= PAT_OFF;
			col_q     <= CSEL_WHITE;
			src_q     <= SRC_NORMAL;
			pct_q     <= '0;
			wrap_q    <= 1'b0;
			mode_q    <= M_FILL;
			color_q   <= RGB_OFF;
			mid_q     <= 1'b0;
			gauge_a_q <= '0;
			idx_q     <= '0;
			last_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						pos_q   <= pos_n;
						cnt_q   <= cnt_n;
						lit_q   <= lit_n;
						lvl_q   <= lvl_n;
						rise_q  <= rise_n;
						wrap_q  <= wrap_n;
						pat_q   <= cfg.pattern_select;
						col_q   <= cfg.color_select;
						src_q   <= src_n;
						pct_q   <= cfg.charge_percent;
						state_q <= S_PREP;
					end else if (restart) begin
						pos_q  <= '0;
						cnt_q  <= '0;
						lit_q  <= 1'b1;
						lvl_q  <= '0;
						rise_q <= 1'b1;
					end
				end
				S_PREP: begin
					mode_q    <= mode_p;
					color_q   <= color_p;
					mid_q     <= (pat_q == PAT_RIGHT);
					gauge_a_q <= CW'(pct_q) * CW'(PIXEL_COUNT);
					idx_q     <= start_p;
					last_q    <= last_p;
					state_q   <= S_SWEEP;
				end
				S_SWEEP: begin
					if (idx_q == last_q) begin
						state_q <= S_DONE;
					end else begin
						idx_q <= idx_q + AW'(1);
					end
				end
				S_DONE: begin
					if (finish) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/led_strip_pattern_engine_unit.sv -----
// Top level of the LED strip pattern engine: registers, read path and frame store.
//
// The engine keeps one frame of PIXEL_COUNT packed pixels (red in bits 23:16, green in
// 15:8, blue in 7:0) in a single synchronous RAM. A read item (req_type 1) fetches one
// pixel and returns it with the current frame source; reads flow one per cycle while no
// frame is rendering and the output is not stalled, since the RAM read is registered at
// acceptance and the result then moves into its own output register. A tick item
// (req_type 0) renders the next frame: acceptance latches the settings and advances the
// animation, the prepare state sets up the frame color (fade scaling happens here), then
// the renderer writes the RAM one pixel per cycle (a wipe step may paint a single pixel),
// so a tick holds the input until its frame is stored and its result enters the read stage.
// The tick's result (pixel_color 0) is released only once the frame is stored. The
// store has one valid flag per pixel, cleared at reset, so an unwritten pixel reads as
// off; an index at or beyond PIXEL_COUNT reads as 0. Emergency paints the strip red,
// charging shows the green gauge with a yellow pixel blinking every 8 ticks, and
// otherwise the selected pattern runs in the selected color. Writing a new pattern or
// color restarts the animation. Configuration is written through a plain write port and
// must only change while no item is in flight.
module led_strip_pattern_engine_unit import lspe_pkg::*; #(
	parameter int PIXEL_COUNT = 96,
	localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [2:0]        cfg_index,
	input  logic [DATA_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              req_type,
	input  logic [6:0]        pixel_index,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [PIX_W-1:0]  pixel_color,
	output logic [SRC_W-1:0]  active_source
);

	localparam int IW = (AW > 7) ? AW : 7;

	// Configuration registers.
	cfg_t cfg_q;
	logic restart;

	assign restart = cfg_we &&
		((cfg_index == REG_PATTERN && cfg_data[2:0] != cfg_q.pattern_select) ||
		 (cfg_index == REG_COLOR && cfg_data[2:0] != cfg_q.color_select));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_select <= PAT_OFF;
			cfg_q.color_select   <= CSEL_WHITE;
			cfg_q.emergency_on   <= 1'b0;
			cfg_q.charging_on    <= 1'b0;
			cfg_q.charge_percent <= '0;
			cfg_q.blink_period   <= PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_PATTERN:  cfg_q.pattern_select <= cfg_data[2:0];
				REG_COLOR:    cfg_q.color_select   <= cfg_data[2:0];
				REG_EMERG:    cfg_q.emergency_on   <= cfg_data[0];
				REG_CHARGING: cfg_q.charging_on    <= cfg_data[0];
				REG_PERCENT:  cfg_q.charge_percent <= cfg_data[PCT_W-1:0];
				REG_PERIOD:   cfg_q.blink_period   <= cfg_data[PER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The source reported with every result comes from the registers at acceptance.
	logic [SRC_W-1:0] cur_src;
	assign cur_src = cfg_q.emergency_on ? SRC_EMERG
		: (cfg_q.charging_on ? SRC_GAUGE : SRC_NORMAL);

	// Renderer.
	rstat_t        rstat;
	logic          tick_start;
	logic          finish;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [23:0]   wr_data;

	lspe_render #(.PIXEL_COUNT(PIXEL_COUNT)) u_render (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.restart (restart),
		.start   (tick_start),
		.finish  (finish),
		.stat    (rstat),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// Read stage (s1) and output register.
	logic             s1_valid_q;
	logic             s1_tick_q;
	logic             s1_hit_q;
	logic [SRC_W-1:0] s1_src_q;
	logic [SRC_W-1:0] tick_src_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] pixel_color_q;
	logic [SRC_W-1:0] active_source_q;
	logic             s1_adv;
	logic             s1_open;
	logic             accept;
	logic             rd_en;
	logic [IW-1:0]    idx_w;
	logic [AW-1:0]    rd_addr;
	logic             in_range;
	logic [23:0]      rd_data;

	assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready);
	assign s1_open    = !s1_valid_q || s1_adv;
	assign in_ready   = rstat.idle && s1_open;
	assign accept     = in_valid && in_ready;
	assign tick_start = accept && !req_type;
	assign finish     = rstat.done && s1_open;
	assign idx_w      = IW'(pixel_index);
	assign rd_addr    = idx_w[AW-1:0];
	assign in_range   = (9'(pixel_index) < 9'(PIXEL_COUNT));
	assign rd_en      = accept && req_type && in_range;

	// One valid flag per pixel: an unwritten pixel reads as off.
	logic [PIXEL_COUNT-1:0] pix_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_valid_q <= '0;
		end else if (wr_en) begin
			pix_valid_q[wr_addr] <= 1'b1;
		end
	end

	lspe_ram #(.WIDTH(PIX_W), .DEPTH(PIXEL_COUNT)) u_frame_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q      <= 1'b0;
			s1_tick_q       <= 1'b0;
			s1_hit_q        <= 1'b0;
			s1_src_q        <= SRC_NORMAL;
			tick_src_q      <= SRC_NORMAL;
			out_valid_q     <= 1'b0;
			pixel_color_q   <= '0;
			active_source_q <= SRC_NORMAL;
		end else begin
			if (tick_start) begin
				tick_src_q <= cur_src;
			end
			// A read enters s1 at acceptance; a tick enters once its frame is stored.
			if (accept && req_type) begin
				s1_valid_q <= 1'b1;
				s1_tick_q  <= 1'b0;
				s1_hit_q   <= in_range && pix_valid_q[rd_addr];
				s1_src_q   <= cur_src;
			end else if (finish) begin
				s1_valid_q <= 1'b1;
				s1_tick_q  <= 1'b1;
				s1_hit_q   <= 1'b0;
				s1_src_q   <= tick_src_q;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q     <= 1'b1;
				pixel_color_q   <= (!s1_tick_q && s1_hit_q) ? rd_data : RGB_OFF;
				active_source_q <= s1_src_q;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign pixel_color   = pixel_color_q;
	assign active_source = active_source_q;

	// The frame store is never read while the renderer writes it.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("frame store read during a render sweep");

	// A pending read is held while the output register is stalled.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && out_valid_q && !out_ready) |=> (s1_valid_q && $stable(s1_src_q)))
		else $error("read stage lost an item under back-pressure");

	// Items are only taken while no frame is being rendered.
	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(!rstat.idle) |-> !tick_start && !rd_en)
		else $error("item accepted while a frame was rendering");

	// Reported source is always a defined code.
	a_src_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (active_source == SRC_NORMAL || active_source == SRC_GAUGE ||
			active_source == SRC_EMERG))
		else $error("undefined frame source reported");

endmodule
